/* hw/rtl/ogsd_pkg.sv */
// ----------------------------------------------------------------------------
// ogsd_pkg
// Shared types and constants of the Ogg page segment demux: result record,
// segment table entry, table write port and the result codes.
// ----------------------------------------------------------------------------
package ogsd_pkg;

  // largest segment count kept per page
  localparam int MAX_SEGMENTS = 255;
  // segment table address and segment count widths
  localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);

  // page header layout
  localparam logic [31:0] CAPTURE_WORD = 32'h4F676753;
  localparam int          CAPTURE_LEN  = 4;
  localparam int          HEADER_SKIP  = 22;
  localparam int          HDR_W        = 5;

  // result queue between parser and output side
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);

  // result kinds
  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_EMPTY_RUN = 3'd1,
    KIND_MISMATCH  = 3'd2,
    KIND_CLEAN_END = 3'd3,
    KIND_TRUNCATED = 3'd4
  } kind_t;

  // one result record
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload;
    logic        segment_last;
    logic        page_last;
    logic [7:0]  empty_after;
  } result_t;

  // one nonzero segment: its size and the empty segments behind it
  typedef struct packed {
    logic [7:0] zeros;
    logic [7:0] size;
  } seg_entry_t;

  // segment table write port
  typedef struct packed {
    logic              en;
    logic [SEG_AW-1:0] addr;
    seg_entry_t        data;
  } seg_wr_t;

endpackage

/* hw/rtl/ogsd_seg_table.sv */
// ----------------------------------------------------------------------------
// ogsd_seg_table
// Compact list of the nonzero segments of the current page. One write and
// one registered read per cycle; a write to the address being read is
// forwarded to the read data.
// ----------------------------------------------------------------------------
module ogsd_seg_table (
  input  logic                          clk,
  input  ogsd_pkg::seg_wr_t             wr,
  input  logic [ogsd_pkg::SEG_AW-1:0]   rd_addr,
  output ogsd_pkg::seg_entry_t          rd_data
);
  import ogsd_pkg::*;

  seg_entry_t mem [MAX_SEGMENTS];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en && (int'(wr.addr) < MAX_SEGMENTS)) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read with write forwarding
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == rd_addr)) begin
      rd_data <= wr.data;
    end else if (int'(rd_addr) < MAX_SEGMENTS) begin
      rd_data <= mem[rd_addr];
    end else begin
      rd_data <= '0;
    end
  end

endmodule

/* hw/rtl/ogsd_parser.sv */
// ----------------------------------------------------------------------------
// ogsd_parser
// Front end: takes one stream byte per transaction, tracks capture search,
// header skip, table load and payload, and forms at most one result.
// ----------------------------------------------------------------------------
module ogsd_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [7:0]                    data_byte,
  input  logic                          stream_end,
  output logic                          res_valid,
  output ogsd_pkg::result_t             res,
  output ogsd_pkg::seg_wr_t             seg_wr,
  output logic [ogsd_pkg::SEG_AW-1:0]   rd_addr,
  input  ogsd_pkg::seg_entry_t          rd_data
);
  import ogsd_pkg::*;

  typedef enum logic [1:0] {
    PH_CAPTURE,
    PH_HEADER,
    PH_TABLE,
    PH_PAYLOAD
  } phase_t;

  phase_t            phase, phase_next;
  logic [23:0]       pattern_shift, pattern_shift_next;
  logic [HDR_W-1:0]  header_count, header_count_next;
  logic [CNT_W-1:0]  seg_total, seg_total_next;
  logic [CNT_W-1:0]  load_index, load_index_next;
  logic [CNT_W-1:0]  leading_zeros, leading_zeros_next;
  logic [CNT_W-1:0]  nz_count, nz_count_next;
  logic [7:0]        cur_size, cur_size_next;
  logic [7:0]        cur_zeros, cur_zeros_next;
  logic [7:0]        first_size, first_size_next;
  logic [7:0]        first_zeros, first_zeros_next;
  logic [SEG_AW-1:0] rd_k, rd_k_next;
  logic [7:0]        bytes_left, bytes_left_next;
  logic [7:0]        act_zeros, act_zeros_next;

  logic [31:0]       word;
  logic [CNT_W:0]    k_plus1;
  logic [CNT_W:0]    k_plus2;
  logic              is_last;
  logic              next_is_last;
  seg_entry_t        next_entry;

  // position of the current segment in the compact list
  assign word         = {pattern_shift, data_byte};
  assign k_plus1      = (CNT_W + 1)'(rd_k) + 1'b1;
  assign k_plus2      = (CNT_W + 1)'(rd_k) + 2'd2;
  assign is_last      = (k_plus1 == (CNT_W + 1)'(nz_count));
  assign next_is_last = (k_plus2 == (CNT_W + 1)'(nz_count));

  // the last nonzero segment lives in registers, the others in the table
  always_comb begin
    if (next_is_last) begin
      next_entry.zeros = cur_zeros;
      next_entry.size  = cur_size;
    end else begin
      next_entry = rd_data;
    end
  end

  // next state and result
  always_comb begin
    phase_next         = phase;
    pattern_shift_next = pattern_shift;
    header_count_next  = header_count;
    seg_total_next     = seg_total;
    load_index_next    = load_index;
    leading_zeros_next = leading_zeros;
    nz_count_next      = nz_count;
    cur_size_next      = cur_size;
    cur_zeros_next     = cur_zeros;
    first_size_next    = first_size;
    first_zeros_next   = first_zeros;
    rd_k_next          = rd_k;
    bytes_left_next    = bytes_left;
    act_zeros_next     = act_zeros;

    res_valid = 1'b0;
    res       = '0;
    seg_wr    = '0;
    rd_addr   = (phase == PH_PAYLOAD) ? SEG_AW'(k_plus1) : SEG_AW'(1);

    if (take) begin
      if (stream_end) begin
        // end of stream: report and return to reset
        res_valid = 1'b1;
        res.kind  = (phase == PH_CAPTURE && header_count == '0) ? KIND_CLEAN_END
                                                                : KIND_TRUNCATED;
        phase_next         = PH_CAPTURE;
        pattern_shift_next = '0;
        header_count_next  = '0;
        seg_total_next     = '0;
        load_index_next    = '0;
        leading_zeros_next = '0;
        nz_count_next      = '0;
        rd_k_next          = '0;
        bytes_left_next    = '0;
      end else begin
        unique case (phase)
          // collect four bytes and compare with the capture pattern
          PH_CAPTURE: begin
            if (header_count < HDR_W'(CAPTURE_LEN - 1)) begin
              header_count_next  = header_count + 1'b1;
              pattern_shift_next = word[23:0];
            end else begin
              header_count_next  = '0;
              pattern_shift_next = '0;
              if (word == CAPTURE_WORD) begin
                phase_next = PH_HEADER;
              end else begin
                res_valid = 1'b1;
                res.kind  = KIND_MISMATCH;
              end
            end
          end

          // skip header, then take the segment count
          PH_HEADER: begin
            if (header_count < HDR_W'(HEADER_SKIP)) begin
              header_count_next = header_count + 1'b1;
            end else begin
              header_count_next = '0;
              if (data_byte == 8'd0) begin
                phase_next = PH_CAPTURE;
              end else begin
                seg_total_next = (int'(data_byte) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS)
                                                                  : CNT_W'(data_byte);
                load_index_next    = '0;
                leading_zeros_next = '0;
                nz_count_next      = '0;
                cur_zeros_next     = '0;
                phase_next         = PH_TABLE;
              end
            end
          end

          // fold the segment table into the compact list
          PH_TABLE: begin
            if (data_byte != 8'd0) begin
              if (leading_zeros < load_index) begin
                // close the previous nonzero segment
                seg_wr.en   = 1'b1;
                seg_wr.addr = SEG_AW'(nz_count - 1'b1);
                seg_wr.data = {cur_zeros, cur_size};
                if (nz_count == CNT_W'(1)) begin
                  first_zeros_next = cur_zeros;
                end
              end else begin
                first_size_next = data_byte;
              end
              cur_size_next  = data_byte;
              cur_zeros_next = '0;
              nz_count_next  = nz_count + 1'b1;
            end else if (leading_zeros == load_index) begin
              leading_zeros_next = leading_zeros + 1'b1;
            end else begin
              cur_zeros_next = cur_zeros + 1'b1;
            end
            load_index_next = load_index + 1'b1;

            if (load_index_next >= seg_total) begin
              if (leading_zeros_next >= seg_total) begin
                // page of empty segments only
                res_valid       = 1'b1;
                res.kind        = KIND_EMPTY_RUN;
                res.page_last   = 1'b1;
                res.empty_after = 8'(seg_total);
                phase_next      = PH_CAPTURE;
              end else begin
                phase_next = PH_PAYLOAD;
                rd_k_next  = '0;
                if (nz_count_next == CNT_W'(1)) begin
                  bytes_left_next = cur_size_next;
                  act_zeros_next  = cur_zeros_next;
                end else begin
                  bytes_left_next = first_size_next;
                  act_zeros_next  = first_zeros_next;
                end
                // run of empty segments ahead of the first payload
                if (leading_zeros_next != '0) begin
                  res_valid       = 1'b1;
                  res.kind        = KIND_EMPTY_RUN;
                  res.empty_after = 8'(leading_zeros_next);
                end
              end
            end
          end

          // pass payload through, marking segment and page ends
          PH_PAYLOAD: begin
            res_valid   = 1'b1;
            res.kind    = KIND_PAYLOAD;
            res.payload = data_byte;
            if (bytes_left > 8'd1) begin
              bytes_left_next = bytes_left - 1'b1;
            end else begin
              res.segment_last = 1'b1;
              res.empty_after  = act_zeros;
              bytes_left_next  = '0;
              if (is_last) begin
                res.page_last = 1'b1;
                phase_next    = PH_CAPTURE;
              end else begin
                rd_k_next       = SEG_AW'(k_plus1);
                bytes_left_next = next_entry.size;
                act_zeros_next  = next_entry.zeros;
                rd_addr         = SEG_AW'(k_plus2);
              end
            end
          end

          default: begin
            phase_next = PH_CAPTURE;
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_CAPTURE;
      pattern_shift <= '0;
      header_count  <= '0;
      seg_total     <= '0;
      load_index    <= '0;
      leading_zeros <= '0;
      nz_count      <= '0;
      rd_k          <= '0;
      bytes_left    <= '0;
    end else begin
      phase         <= phase_next;
      pattern_shift <= pattern_shift_next;
      header_count  <= header_count_next;
      seg_total     <= seg_total_next;
      load_index    <= load_index_next;
      leading_zeros <= leading_zeros_next;
      nz_count      <= nz_count_next;
      rd_k          <= rd_k_next;
      bytes_left    <= bytes_left_next;
    end
  end

  // segment data registers
  always_ff @(posedge clk) begin
    cur_size    <= cur_size_next;
    cur_zeros   <= cur_zeros_next;
    first_size  <= first_size_next;
    first_zeros <= first_zeros_next;
    act_zeros   <= act_zeros_next;
  end

endmodule

/* hw/rtl/ogsd_result_queue.sv */
// ----------------------------------------------------------------------------
// ogsd_result_queue
// Back end: short queue of result records between the parser and the
// result ports, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module ogsd_result_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  ogsd_pkg::result_t   wr_data,
  output logic                full,
  output logic                empty,
  input  logic                rd_en,
  output ogsd_pkg::result_t   rd_data
);
  import ogsd_pkg::*;

  result_t         entries [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  // status and head of queue
  assign full    = (count == (Q_AW + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/ogg_page_segment_demux_unit.sv */
// ----------------------------------------------------------------------------
// ogg_page_segment_demux_unit
// Ogg page demultiplexer: one stream byte per transaction in, payload bytes
// with segment and page marks, empty segment runs and stream events out.
//
//   channel  direction  handshake            payload
//   input    in         push / full          data_byte, stream_end
//   result   out        empty / pop          kind, payload, segment_last,
//                                            page_last, empty_after
//
// One byte is taken every cycle while full is low; a result is written into
// the result queue as its byte is taken and reaches the result ports once
// the results ahead of it are popped. A segment end takes the next entry
// from the segment table, prefetched one entry ahead, or from registers for
// the last nonzero segment, so back-to-back segments cost nothing. full rises
// only when four results wait to be popped. Synchronous reset clears parser
// state and empties the result queue; no table clearing pass is needed.
// ----------------------------------------------------------------------------
module ogg_page_segment_demux_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       stream_end,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] kind,
  output logic [7:0] payload,
  output logic       segment_last,
  output logic       page_last,
  output logic [7:0] empty_after
);
  import ogsd_pkg::*;

  logic              take;
  logic              res_valid;
  result_t           res;
  result_t           head;
  seg_wr_t           seg_wr;
  logic [SEG_AW-1:0] rd_addr;
  seg_entry_t        rd_data;

  // input transaction
  assign take = push && !full;

  // front end
  ogsd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (data_byte),
    .stream_end (stream_end),
    .res_valid  (res_valid),
    .res        (res),
    .seg_wr     (seg_wr),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  // segment table
  ogsd_seg_table u_seg_table (
    .clk     (clk),
    .wr      (seg_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result queue
  ogsd_result_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .full    (full),
    .empty   (empty),
    .rd_en   (pop && !empty),
    .rd_data (head)
  );

  // result ports
  assign kind         = head.kind;
  assign payload      = head.payload;
  assign segment_last = head.segment_last;
  assign page_last    = head.page_last;
  assign empty_after  = head.empty_after;

endmodule

/* bench/ogg_page_segment_demux_unit_tb.sv */
// ----------------------------------------------------------------------------
// ogg_page_segment_demux_unit_tb
// Self-checking bench for the Ogg page segment demux. A short table of
// capture and end-of-stream cases runs first. It is followed by hand-shaped
// pages: leading, trailing and all-empty segment runs, a page with no
// segments, a full 255-byte segment and a page with 255 segments. Random
// pages come last, mixed with noise, near-miss capture words and truncated
// pages. Results are checked against hand-typed ones in the opening table,
// else against a bit-exact parser model. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module ogg_page_segment_demux_unit_tb;
  import ogsd_pkg::*;

  localparam int TOTAL_ITEMS = 1000;
  localparam int STALL_LIMIT = 2000;

  // parser phases of the bench model
  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_HEADER,
    PH_LOAD,
    PH_BODY
  } phase_t;

  // one input transaction, with an optional hand-typed result
  typedef struct packed {
    logic [7:0] d;
    logic       se;
    logic       typed;
    logic       has;
    kind_t      k;
  } stim_t;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] data_byte;
  logic       stream_end;
  logic       empty;
  logic       pop;
  logic [2:0] kind;
  logic [7:0] payload;
  logic       segment_last;
  logic       page_last;
  logic [7:0] empty_after;

  // bench-side parser state
  phase_t     ph;
  logic [23:0] cap_shift;
  logic [4:0]  hdr_cnt;
  logic [7:0]  seg_cnt;
  logic [7:0]  load_idx;
  logic [7:0]  read_idx;
  logic [7:0]  left;
  logic [7:0]  lead_zeros;
  logic [7:0]  last_nz;
  seg_entry_t  seg_mem [MAX_SEGMENTS];

  result_t pending_results [$];
  stim_t   cur_stim;
  stim_t   opening [25];
  int      fails;
  int      quiet_cycles;
  int      items_sent;
  int      cut_after;
  bit      page_cut;
  bit      calm;

  ogg_page_segment_demux_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .stream_end   (stream_end),
    .empty        (empty),
    .pop          (pop),
    .kind         (kind),
    .payload      (payload),
    .segment_last (segment_last),
    .page_last    (page_last),
    .empty_after  (empty_after)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // parser model: back to the state after reset
  function automatic void clear_parser();
    ph         = PH_SEARCH;
    cap_shift  = '0;
    hdr_cnt    = '0;
    seg_cnt    = '0;
    load_idx   = '0;
    read_idx   = '0;
    left       = '0;
    lead_zeros = '0;
    last_nz    = '0;
    foreach (seg_mem[i]) seg_mem[i] = '0;
  endfunction

  function automatic seg_entry_t entry_at(input logic [7:0] idx);
    return (idx < MAX_SEGMENTS) ? seg_mem[idx] : seg_entry_t'('0);
  endfunction

  // parser model: one byte in, at most one result out
  function automatic bit parse_byte(input logic [7:0] b, input logic se,
                                    output result_t r);
    logic [31:0] word;
    seg_entry_t  e;
    int          n;
    int          idx;
    r = '0;
    if (se) begin
      r.kind = (ph == PH_SEARCH && hdr_cnt == 0) ? KIND_CLEAN_END : KIND_TRUNCATED;
      clear_parser();
      return 1'b1;
    end
    case (ph)
      PH_SEARCH: begin
        // fixed four-byte windows, no sliding search
        word = {cap_shift, b};
        hdr_cnt = hdr_cnt + 1'b1;
        if (hdr_cnt < CAPTURE_LEN) begin
          cap_shift = word[23:0];
          return 1'b0;
        end
        hdr_cnt = '0;
        cap_shift = '0;
        if (word == CAPTURE_WORD) begin
          ph = PH_HEADER;
          return 1'b0;
        end
        r.kind = KIND_MISMATCH;
        return 1'b1;
      end
      PH_HEADER: begin
        if (hdr_cnt < HEADER_SKIP) begin
          hdr_cnt = hdr_cnt + 1'b1;
          return 1'b0;
        end
        hdr_cnt = '0;
        n = b;
        // page with no segments is dropped
        if (n == 0) begin
          ph = PH_SEARCH;
          return 1'b0;
        end
        if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
        seg_cnt    = 8'(n);
        load_idx   = '0;
        lead_zeros = '0;
        last_nz    = '0;
        ph = PH_LOAD;
        return 1'b0;
      end
      PH_LOAD: begin
        // nonzero sizes get an entry, zeros fold into the entry before them
        idx = load_idx;
        if (idx < MAX_SEGMENTS) begin
          if (b != 0) begin
            seg_mem[idx] = '{zeros: 8'd0, size: b};
            last_nz = 8'(idx);
          end else if (lead_zeros == load_idx) begin
            lead_zeros = lead_zeros + 1'b1;
          end else if (last_nz < MAX_SEGMENTS) begin
            seg_mem[last_nz].zeros = seg_mem[last_nz].zeros + 1'b1;
          end
        end
        load_idx = load_idx + 1'b1;
        if (load_idx < seg_cnt) return 1'b0;
        // every segment empty: one run ends the page
        if (lead_zeros >= seg_cnt) begin
          ph = PH_SEARCH;
          r.kind = KIND_EMPTY_RUN;
          r.page_last = 1'b1;
          r.empty_after = seg_cnt;
          return 1'b1;
        end
        ph = PH_BODY;
        read_idx = lead_zeros;
        left = entry_at(read_idx).size;
        if (lead_zeros > 0) begin
          r.kind = KIND_EMPTY_RUN;
          r.empty_after = lead_zeros;
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        e = entry_at(read_idx);
        r.kind = KIND_PAYLOAD;
        r.payload = b;
        if (left > 1) begin
          left = left - 1'b1;
          return 1'b1;
        end
        left = '0;
        r.segment_last = 1'b1;
        r.empty_after = e.zeros;
        if (read_idx >= last_nz) begin
          ph = PH_SEARCH;
          r.page_last = 1'b1;
          return 1'b1;
        end
        read_idx = read_idx + 8'd1 + e.zeros;
        left = entry_at(read_idx).size;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // byte values with the extremes made common
  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 8'h00;
    if (r < 10) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic stim_t raw(input logic [7:0] d);
    return '{d: d, se: 1'b0, typed: 1'b0, has: 1'b0, k: KIND_PAYLOAD};
  endfunction

  // monitor: check popped results, predict accepted bytes
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    result_t calc;
    bit      made;
    if (rst) begin
      clear_parser();
      quiet_cycles = 0;
    end else begin
      if (pop && !empty) begin
        got = result_t'({kind, payload, segment_last, page_last, empty_after});
        if (pending_results.size() == 0) begin
          $error("result with no expectation: kind %0d payload %0d", kind, payload);
          fails++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", {5'd0, want.kind}, {5'd0, got.kind});
          check_field("payload", want.payload, got.payload);
          check_field("segment_last", {7'd0, want.segment_last}, {7'd0, got.segment_last});
          check_field("page_last", {7'd0, want.page_last}, {7'd0, got.page_last});
          check_field("empty_after", want.empty_after, got.empty_after);
        end
      end
      if (push && !full) begin
        made = parse_byte(data_byte, stream_end, calc);
        if (cur_stim.typed) begin
          if (cur_stim.has) pending_results.push_back('{kind: cur_stim.k, default: '0});
        end else if (made) begin
          pending_results.push_back(calc);
        end
      end
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // watchdog on cycles with no transaction at all
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(negedge clk);
    $display("Some tests failed");
    $finish;
  end

  // result side: random pop stalls
  initial begin
    pop = 1'b0;
    forever begin
      int n;
      n = pick_gap();
      if (n > 0) begin
        pop <= 1'b0;
        repeat (n) @(negedge clk);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // one input transaction; called and returns at a falling edge
  task automatic send_byte(input stim_t s, input bit counted);
    int n;
    if (page_cut) return;
    if (cut_after == 0) begin
      s.se = 1'b1;
      page_cut = 1'b1;
    end
    if (cut_after >= 0) cut_after--;
    n = pick_gap();
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(negedge clk);
    end
    push       <= 1'b1;
    data_byte  <= s.d;
    stream_end <= s.se;
    cur_stim   <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    if (counted) items_sent++;
    @(negedge clk);
  endtask

  // capture word, skipped header, segment table, then the payload
  task automatic send_page(input logic [7:0] sizes [$]);
    for (int i = 0; i < CAPTURE_LEN; i++) send_byte(raw(CAPTURE_WORD[31 - 8 * i -: 8]), 1'b1);
    repeat (HEADER_SKIP) send_byte(raw(rand_byte()), 1'b1);
    send_byte(raw(8'(sizes.size())), 1'b1);
    foreach (sizes[i]) send_byte(raw(sizes[i]), 1'b1);
    foreach (sizes[i]) repeat (sizes[i]) send_byte(raw(rand_byte()), 1'b1);
    cut_after = -1;
    page_cut = 1'b0;
  endtask

  task automatic make_shape(output logic [7:0] q [$], input int nseg, input int zero_pct,
                            input int max_size);
    q = {};
    repeat (nseg) begin
      if ($urandom_range(0, 99) < zero_pct) q.push_back(8'd0);
      else q.push_back(8'($urandom_range(1, max_size)));
    end
  endtask

  // hold off input until every expected result is out
  task automatic drain();
    push <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // stimulus
  initial begin
    logic [7:0]  shape [$];
    logic [31:0] w;
    int          r;
    int          nseg;
    int          zero_pct;
    int          mid_mark;
    bit          mid_drained;
    rst         = 1'b1;
    push        = 1'b0;
    data_byte   = 8'h00;
    stream_end  = 1'b0;
    cur_stim    = '0;
    fails       = 0;
    items_sent  = 0;
    cut_after   = -1;
    page_cut    = 1'b0;
    calm        = 1'b0;
    mid_drained = 1'b0;
    // d, stream_end, typed, has result, kind
    opening = '{
      '{8'h00, 1'b1, 1'b1, 1'b1, KIND_CLEAN_END},  // end right after reset
      '{8'hFF, 1'b1, 1'b1, 1'b1, KIND_CLEAN_END},  // end again, byte ignored
      '{8'h00, 1'b0, 1'b1, 1'b0, KIND_PAYLOAD},
      '{8'h00, 1'b0, 1'b1, 1'b0, KIND_PAYLOAD},
      '{8'h00, 1'b0, 1'b1, 1'b0, KIND_PAYLOAD},
      '{8'h00, 1'b0, 1'b1, 1'b1, KIND_MISMATCH},   // all-zero window
      '{8'hFF, 1'b0, 1'b1, 1'b0, KIND_PAYLOAD},
      '{8'hFF, 1'b0, 1'b1, 1'b0, KIND_PAYLOAD},
      '{8'hFF, 1'b0, 1'b1, 1'b0, KIND_PAYLOAD},
      '{8'hFF, 1'b0, 1'b1, 1'b1, KIND_MISMATCH},   // all-ones window
      '{8'h4F, 1'b0, 1'b1, 1'b0, KIND_PAYLOAD},
      '{8'h67, 1'b0, 1'b1, 1'b0, KIND_PAYLOAD},
      '{8'h67, 1'b0, 1'b1, 1'b0, KIND_PAYLOAD},
      '{8'h00, 1'b1, 1'b1, 1'b1, KIND_TRUNCATED},  // end inside the capture word
      '{8'h4F, 1'b0, 1'b1, 1'b0, KIND_PAYLOAD},
      '{8'h67, 1'b0, 1'b1, 1'b0, KIND_PAYLOAD},
      '{8'h67, 1'b0, 1'b1, 1'b0, KIND_PAYLOAD},
      '{8'h54, 1'b0, 1'b1, 1'b1, KIND_MISMATCH},   // last capture byte off by one
      '{8'h53, 1'b0, 1'b1, 1'b0, KIND_PAYLOAD},
      '{8'hFF, 1'b1, 1'b1, 1'b1, KIND_TRUNCATED},  // end after one byte
      '{8'h4F, 1'b0, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'h67, 1'b0, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'h67, 1'b0, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'h53, 1'b0, 1'b0, 1'b0, KIND_PAYLOAD},
      '{8'hAA, 1'b1, 1'b1, 1'b1, KIND_TRUNCATED}   // end in the header skip
    };
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (opening[i]) send_byte(opening[i], 1'b1);

    // hand-shaped pages
    shape = {8'd0, 8'd0, 8'd3, 8'd0, 8'd2};  // leading empty run
    send_page(shape);
    shape = {8'd0, 8'd0, 8'd0};              // nothing but empty segments
    send_page(shape);
    shape = {};                              // no segments at all
    send_page(shape);
    shape = {8'd2, 8'd0, 8'd0};              // trailing empty run
    send_page(shape);
    shape = {8'd255};                        // largest segment
    send_page(shape);
    make_shape(shape, MAX_SEGMENTS, 60, 1);  // largest segment count
    send_page(shape);
    send_byte('{d: rand_byte(), se: 1'b1, typed: 1'b0, has: 1'b0, k: KIND_PAYLOAD}, 1'b1);
    drain();

    // random part
    mid_mark = items_sent + (TOTAL_ITEMS - items_sent) / 2;
    while (items_sent < TOTAL_ITEMS) begin
      calm = ($urandom_range(0, 6) == 0);
      if (!mid_drained && items_sent >= mid_mark) begin
        mid_drained = 1'b1;
        drain();
      end
      r = $urandom_range(0, 99);
      if (r < 78) begin
        // well-formed page, or one cut short by an end of stream
        if (r >= 70) cut_after = $urandom_range(0, 40);
        nseg = ($urandom_range(0, 49) == 0) ? $urandom_range(9, MAX_SEGMENTS)
                                             : $urandom_range(1, 8);
        case ($urandom_range(0, 7))
          0:       zero_pct = 100;
          1, 2:    zero_pct = 0;
          default: zero_pct = 30;
        endcase
        make_shape(shape, nseg, zero_pct,
                   (nseg <= 8 && $urandom_range(0, 19) == 0) ? 255 : 6);
        send_page(shape);
      end else if (r < 86) begin
        // noise in whole capture windows
        repeat (4 * $urandom_range(1, 3)) send_byte(raw(rand_byte()), 1'b1);
      end else if (r < 93) begin
        // capture word with one bit flipped
        w = CAPTURE_WORD ^ (32'd1 << $urandom_range(0, 31));
        for (int i = 0; i < CAPTURE_LEN; i++) send_byte(raw(w[31 - 8 * i -: 8]), 1'b1);
      end else if (r < 97) begin
        send_byte('{d: rand_byte(), se: 1'b1, typed: 1'b0, has: 1'b0, k: KIND_PAYLOAD},
                  1'b1);
      end else begin
        shape = {};
        send_page(shape);
      end
    end

    // wind down
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
